@@ rtl/log_record_validator_macros.svh @@
// Assertion helpers shared by the validator RTL.
`ifndef LOG_RECORD_VALIDATOR_MACROS_SVH
`define LOG_RECORD_VALIDATOR_MACROS_SVH

// Concurrent check on every rising clock edge, held off while reset is asserted.
`define LRV_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Check that a condition in one cycle implies another in the next cycle.
`define LRV_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

@@ rtl/lrv_pkg.sv @@
package lrv_pkg;

  // Record format constants.
  localparam int unsigned LRV_HEADER_BYTES = 16;
  localparam logic [31:0] LRV_MAGIC        = 32'h474C_584C;
  localparam logic [7:0]  LRV_VERSION      = 8'd1;
  localparam logic [63:0] FNV_BASIS        = 64'hCBF2_9CE4_8422_2325;

  // Result status codes.
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_END        = 3'd1;
  localparam logic [2:0] ST_TRUNC_HDR  = 3'd2;
  localparam logic [2:0] ST_BAD_HDR    = 3'd3;
  localparam logic [2:0] ST_TRUNC_PAY  = 3'd4;
  localparam logic [2:0] ST_SUM_ERR    = 3'd5;

  // Configuration register indexes.
  localparam logic [2:0] CFG_TYPE_A  = 3'd0;
  localparam logic [2:0] CFG_LEN_A   = 3'd1;
  localparam logic [2:0] CFG_TYPE_B  = 3'd2;
  localparam logic [2:0] CFG_LEN_B   = 3'd3;
  localparam logic [2:0] CFG_TYPE_C  = 3'd4;
  localparam logic [2:0] CFG_LEN_C   = 3'd5;
  localparam logic [2:0] CFG_MAX_PAY = 3'd6;

  typedef struct packed {
    logic [7:0] log_byte;
    logic       stream_end;
    logic       empty_end;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  record_type;
    logic [15:0] record_length;
    logic [31:0] good_records;
    logic        last_result;
  } out_item_t;

  // Results written into the result queue in one cycle (zero, one or two).
  typedef struct packed {
    logic [1:0] num;
    out_item_t  first;
    out_item_t  second;
  } lrv_push_t;

  // One FNV-1a step: xor the byte in, then multiply by the 64-bit prime.
  // The prime is 2^40 + 0x1B3, so the product is a short sum of shifts.
  function automatic logic [63:0] fnv_mix(logic [63:0] h, logic [7:0] b);
    logic [63:0] x;
    x = h ^ {56'd0, b};
    return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
  endfunction

endpackage

@@ rtl/log_record_validator.sv @@
// Log record validator. Takes a byte stream one byte per accepted item and
// checks 16-byte headers (magic, version, configured type and length pairs,
// maximum payload) and the 64-bit FNV-1a checksum of each record. It accepts
// one byte every clock cycle while the input is not stalled; the hash step,
// header checks and checksum compare are combinational up to the result queue,
// which registers the results. A byte can cause two results (a record outcome
// plus the end-of-stream report); both enter the queue at once and leave one per
// cycle, so sustained input is one byte per cycle as long as the output drains
// one result per cycle. The input stalls whenever the result queue has fewer than
// two free entries. After a header or checksum error the block drops bytes until
// the end of the stream. The user must write the registers only while the block
// is idle, through cfg_we_i/cfg_idx_i/cfg_data_i; the block does not enforce this.
`include "log_record_validator_macros.svh"

module log_record_validator #(
  parameter int unsigned ResultDepth = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [7:0]         cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  lrv_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output lrv_pkg::out_item_t out_data_o
);
  import lrv_pkg::*;

  localparam logic [1:0] PH_HEADER  = 2'd0;
  localparam logic [1:0] PH_PAYLOAD = 2'd1;
  localparam logic [1:0] PH_SKIP    = 2'd2;

  // Configuration registers.
  logic [7:0] type_a_q, len_a_q, type_b_q, len_b_q, type_c_q, len_c_q, max_pay_q;

  // Parser state.
  logic [1:0]  ph_q, ph_d;
  logic [7:0]  pos_q, pos_d;
  logic [31:0] magic_q, magic_d;
  logic [7:0]  ver_q, ver_d;
  logic [7:0]  type_q, type_d;
  logic [15:0] len_q, len_d;
  logic [63:0] exp_q, exp_d;
  logic [63:0] hash_q, hash_d;
  logic [31:0] cnt_q, cnt_d;

  logic        in_acc;
  logic        room;
  logic        hdr_ok;
  logic        pair_ok;
  logic        fin;
  logic        fin_eq;
  logic        r0_en, r1_en;
  out_item_t   r0, r1;
  lrv_push_t   push;

  assign in_stall_o = !room;
  assign in_acc     = in_valid_i && !in_stall_o;

  // Header acceptance, evaluated against the fields captured so far.
  always_comb begin
    pair_ok = (type_q == type_a_q && len_q == {8'd0, len_a_q}) ||
              (type_q == type_b_q && len_q == {8'd0, len_b_q}) ||
              (type_q == type_c_q && len_q == {8'd0, len_c_q});
    hdr_ok  = (magic_q == LRV_MAGIC) && (ver_q == LRV_VERSION) && pair_ok &&
              (len_q <= {8'd0, max_pay_q});
  end

  // Per-item step: capture, hash, record completion and end-of-stream report.
  always_comb begin
    ph_d    = ph_q;
    pos_d   = pos_q;
    magic_d = magic_q;
    ver_d   = ver_q;
    type_d  = type_q;
    len_d   = len_q;
    exp_d   = exp_q;
    hash_d  = hash_q;
    cnt_d   = cnt_q;
    fin     = 1'b0;
    fin_eq  = 1'b0;
    r0_en   = 1'b0;
    r1_en   = 1'b0;
    r0      = '0;
    r1      = '0;

    if (in_acc && !in_data_i.empty_end) begin
      unique case (ph_q)
        PH_HEADER: begin
          priority if (pos_q < 8'd4) begin
            magic_d[{pos_q[1:0], 3'b000} +: 8] = in_data_i.log_byte;
          end else if (pos_q == 8'd4) begin
            ver_d = in_data_i.log_byte;
          end else if (pos_q == 8'd5) begin
            type_d = in_data_i.log_byte;
          end else if (pos_q == 8'd6) begin
            len_d[7:0] = in_data_i.log_byte;
          end else if (pos_q == 8'd7) begin
            len_d[15:8] = in_data_i.log_byte;
          end else begin
            exp_d[{pos_q[2:0], 3'b000} +: 8] = in_data_i.log_byte;
          end
          if (pos_q >= 8'd4 && pos_q < 8'd8) begin
            hash_d = fnv_mix(hash_q, in_data_i.log_byte);
          end
          if (pos_q == 8'(LRV_HEADER_BYTES - 1)) begin
            if (!hdr_ok) begin
              r0_en            = 1'b1;
              r0.status        = ST_BAD_HDR;
              r0.record_type   = type_q;
              r0.record_length = len_q;
              ph_d             = PH_SKIP;
            end else if (len_q == 16'd0) begin
              // Empty payload: the checksum is complete with this header byte.
              fin    = 1'b1;
              fin_eq = (hash_q == exp_d);
            end else begin
              ph_d  = PH_PAYLOAD;
              pos_d = '0;
            end
          end else begin
            pos_d = pos_q + 8'd1;
          end
        end
        PH_PAYLOAD: begin
          hash_d = fnv_mix(hash_q, in_data_i.log_byte);
          pos_d  = pos_q + 8'd1;
          if (({8'd0, pos_q} + 16'd1) >= len_q) begin
            fin    = 1'b1;
            fin_eq = (hash_d == exp_q);
          end
        end
        default: begin
          // Skipping after an error: bytes are dropped.
        end
      endcase
    end

    // Record completion: checksum verdict.
    if (fin) begin
      r0_en            = 1'b1;
      r0.record_type   = type_q;
      r0.record_length = len_q;
      if (fin_eq) begin
        cnt_d     = (cnt_q == '1) ? cnt_q : cnt_q + 32'd1;
        r0.status = ST_OK;
        ph_d      = PH_HEADER;
        pos_d     = '0;
        magic_d   = '0;
        ver_d     = '0;
        type_d    = '0;
        len_d     = '0;
        exp_d     = '0;
        hash_d    = FNV_BASIS;
      end else begin
        r0.status = ST_SUM_ERR;
        ph_d      = PH_SKIP;
      end
    end
    r0.good_records = cnt_d;

    // End of stream: report where the stream stopped (unless an error was already reported), then start afresh.
    if (in_acc && (in_data_i.empty_end || in_data_i.stream_end)) begin
      r1.good_records = cnt_d;
      unique case (ph_d)
        PH_HEADER: begin
          r1_en     = 1'b1;
          r1.status = (pos_d == 8'd0) ? ST_END : ST_TRUNC_HDR;
        end
        PH_PAYLOAD: begin
          r1_en            = 1'b1;
          r1.status        = ST_TRUNC_PAY;
          r1.record_type   = type_d;
          r1.record_length = len_d;
        end
        default: begin
          // An error was already reported for this stream.
        end
      endcase
      ph_d    = PH_HEADER;
      pos_d   = '0;
      magic_d = '0;
      ver_d   = '0;
      type_d  = '0;
      len_d   = '0;
      exp_d   = '0;
      hash_d  = FNV_BASIS;
      cnt_d   = '0;
    end

    // Pack the results for the queue; the final one carries the last mark.
    r1.last_result = 1'b1;
    r0.last_result = !r1_en;
    push.num       = {1'b0, r0_en} + {1'b0, r1_en};
    push.first     = r0_en ? r0 : r1;
    push.second    = r1;
  end

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      type_a_q  <= '0;
      len_a_q   <= '0;
      type_b_q  <= '0;
      len_b_q   <= '0;
      type_c_q  <= '0;
      len_c_q   <= '0;
      max_pay_q <= 8'hFF;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_TYPE_A:  type_a_q  <= cfg_data_i;
        CFG_LEN_A:   len_a_q   <= cfg_data_i;
        CFG_TYPE_B:  type_b_q  <= cfg_data_i;
        CFG_LEN_B:   len_b_q   <= cfg_data_i;
        CFG_TYPE_C:  type_c_q  <= cfg_data_i;
        CFG_LEN_C:   len_c_q   <= cfg_data_i;
        CFG_MAX_PAY: max_pay_q <= cfg_data_i;
        default: begin
          // Unused index: the write is dropped.
        end
      endcase
    end
  end

  // Parser state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q    <= PH_HEADER;
      pos_q   <= '0;
      magic_q <= '0;
      ver_q   <= '0;
      type_q  <= '0;
      len_q   <= '0;
      exp_q   <= '0;
      hash_q  <= FNV_BASIS;
      cnt_q   <= '0;
    end else begin
      ph_q    <= ph_d;
      pos_q   <= pos_d;
      magic_q <= magic_d;
      ver_q   <= ver_d;
      type_q  <= type_d;
      len_q   <= len_d;
      exp_q   <= exp_d;
      hash_q  <= hash_d;
      cnt_q   <= cnt_d;
    end
  end

  // Result queue between the parser and the output channel.
  lrv_result_fifo #(
    .Depth (ResultDepth)
  ) u_result_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .room_o  (room),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .data_o  (out_data_o)
  );

  `LRV_ASSERT(a_payload_in_range, clk_i, rst_ni,
              (ph_q != PH_PAYLOAD) || (len_q != 16'd0 && {8'd0, pos_q} < len_q),
              "payload position outside the record length")
  `LRV_ASSERT_NEXT(a_end_clears, clk_i, rst_ni,
                   in_acc && (in_data_i.stream_end || in_data_i.empty_end),
                   ph_q == PH_HEADER && pos_q == 8'd0 && cnt_q == 32'd0,
                   "state not cleared after end of stream")
  `LRV_ASSERT_NEXT(a_skip_holds, clk_i, rst_ni,
                   in_acc && ph_q == PH_SKIP && !in_data_i.stream_end &&
                   !in_data_i.empty_end,
                   ph_q == PH_SKIP && $stable(cnt_q),
                   "skipping stream left the skip phase without an end mark")

endmodule

@@ rtl/lrv_result_fifo.sv @@
`include "log_record_validator_macros.svh"

module lrv_result_fifo #(
  parameter int unsigned Depth = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lrv_pkg::lrv_push_t   push_i,
  output logic                 room_o,
  output logic                 valid_o,
  input  logic                 stall_i,
  output lrv_pkg::out_item_t   data_o
);
  import lrv_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  out_item_t          mem_q [Depth];
  logic [PtrW-1:0]    wr_ptr_q, wr_ptr_d, wr_ptr_inc;
  logic [PtrW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]    count_q, count_d;
  logic               pop;

  // Pointer arithmetic wraps at the queue depth.
  always_comb begin
    wr_ptr_inc = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    pop        = valid_o && !stall_i;
    unique case (push_i.num)
      2'd0:    wr_ptr_d = wr_ptr_q;
      2'd1:    wr_ptr_d = wr_ptr_inc;
      default: wr_ptr_d = (wr_ptr_inc == PtrW'(Depth - 1)) ? '0 : wr_ptr_inc + PtrW'(1);
    endcase
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end else begin
      rd_ptr_d = rd_ptr_q;
    end
    count_d = count_q + CntW'(push_i.num) - CntW'(pop);
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage; up to two writes per cycle at consecutive slots.
  always_ff @(posedge clk_i) begin
    if (push_i.num != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.first;
    end
    if (push_i.num == 2'd2) begin
      mem_q[wr_ptr_inc] <= push_i.second;
    end
  end

  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign room_o  = (count_q <= CntW'(Depth - 2));

  `LRV_ASSERT(a_fifo_no_overflow, clk_i, rst_ni, count_q <= CntW'(Depth),
              "result queue holds more items than its depth")
  `LRV_ASSERT(a_fifo_push_room, clk_i, rst_ni, (push_i.num == 2'd0) || room_o,
              "results pushed while the queue lacks room for two")

endmodule
